// ----- src/crc16ri_pkg.sv -----
// crc16ri_pkg: types and constants for the reflected-input crc-16 block
// no dependencies; imported by the interfaces and all crc16ri modules
`default_nettype none

package crc16ri_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] crc_t;

    localparam crc_t CRC_POLY = 16'h1021;
    localparam crc_t CRC_TOP  = 16'h8000;
    localparam crc_t CRC_INIT = 16'h0000;

endpackage

`default_nettype wire

// ----- src/crc16ri_if.sv -----
// crc16ri_in_if and crc16ri_out_if: valid/ready channels for message bytes and crc results
// depends on crc16ri_pkg for payload types
`default_nettype none

interface crc16ri_in_if;
    import crc16ri_pkg::*;

    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crc16ri_out_if;
    import crc16ri_pkg::*;

    logic valid;
    logic ready;
    crc_t crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface

`default_nettype wire

// ----- src/crc16ri_update.sv -----
// crc16ri_update: one byte of crc-16 (poly 0x1021, msb-first) with the input byte reflected
// depends on crc16ri_pkg
`default_nettype none

module crc16ri_update (
    input  crc16ri_pkg::crc_t  crc_in,
    input  crc16ri_pkg::byte_t data_byte,
    output crc16ri_pkg::crc_t  crc_out
);
    import crc16ri_pkg::*;

    byte_t reflected;
    crc_t  step [0:8];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            reflected[i] = data_byte[7 - i];
        end
    end

    assign step[0] = crc_in ^ {reflected, 8'h00};

    genvar g;
    generate
        for (g = 0; g < 8; g++)
        begin : g_shift
            assign step[g + 1] = ((step[g] & CRC_TOP) != '0)
                                 ? ({step[g][14:0], 1'b0} ^ CRC_POLY)
                                 : {step[g][14:0], 1'b0};
        end
    endgenerate

    assign crc_out = step[8];

endmodule

`default_nettype wire

// ----- src/crc16_reflected_input_top.sv -----
// crc16_reflected_input_top: byte-serial crc-16 (reflected input, init zero, no final xor)
// a last byte is held in the input register, then its crc goes to the result register once that is free
// throughput: one byte per cycle, set by the input register feeding the byte update
// network and the single result register; the input stalls only while a result waits
// reset: rst_n async active low clears valids and sets the accumulator to zero
// depends on crc16ri_pkg, crc16ri_in_if, crc16ri_out_if and crc16ri_update
`default_nettype none

module crc16_reflected_input_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    crc16ri_in_if.sink        msg,
    crc16ri_out_if.source     crc
);
    import crc16ri_pkg::*;

    logic  s1_valid_reg;
    byte_t s1_byte_reg;
    logic  s1_last_reg;
    crc_t  acc_reg;
    crc_t  acc_next;
    logic  out_valid_reg;
    crc_t  out_crc_reg;
    crc_t  crc_new;
    logic  out_free;
    logic  s1_fire;
    logic  in_fire;

    crc16ri_update u_update (
        .crc_in    (acc_reg),
        .data_byte (s1_byte_reg),
        .crc_out   (crc_new)
    );

    assign out_free  = !out_valid_reg || crc.ready;
    assign s1_fire   = s1_valid_reg && (!s1_last_reg || out_free);
    assign msg.ready = !s1_valid_reg || s1_fire;
    assign in_fire   = msg.valid && msg.ready;
    assign acc_next  = s1_last_reg ? CRC_INIT : crc_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (msg.ready)
        begin
            s1_valid_reg <= msg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= msg.data_byte;
            s1_last_reg <= msg.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= CRC_INIT;
        end
        else if (s1_fire)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_fire && s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            out_crc_reg <= crc_new;
        end
    end

    assign crc.valid     = out_valid_reg;
    assign crc.crc_value = out_crc_reg;

    // accumulator restarts after the last byte of a message
    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> (acc_reg == CRC_INIT))
        else $error("accumulator not cleared after last byte");

    // a result appears only from a last byte leaving the input register
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_free && !(s1_fire && s1_last_reg)) |=> !out_valid_reg)
        else $error("result without a last byte");

    // an empty input register always takes a new transaction
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> msg.ready)
        else $error("input stalled while empty");

endmodule

`default_nettype wire
